// ===== rtl/spm_pkg.sv =====
// Shared constants, codes and control types for the slotted page manager.
`timescale 1ns / 1ps
package spm_pkg;

	// Page geometry
	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int MAX_SLOTS    = 1024;
	localparam int ENTRY_BYTES  = 4;

	// Field widths
	localparam int LEN_W  = 13;
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;
	localparam int EXT_W  = LEN_W + 1;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_GET    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_INIT   = 2'd3
	} spm_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_NOENTRY = 2'd2,
		ST_DELETED = 2'd3
	} spm_status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;	// capture transaction, read directory entry
		logic exec;	// evaluate, write back, present result
	} spm_ctl_t;

endpackage

// ===== rtl/slotted_page_manager.sv =====
// Top level of the slotted page manager: controller, datapath and checks.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low; busy then stays
// high for one cycle while the directory entry read on the capture edge is
// evaluated and any directory write is made, and the result appears on the
// following cycle with done high for exactly one cycle. The result is not
// held: the receiver must take it in the cycle done is high. A new transaction
// may be started in that same cycle. Reset sets the slot count to zero and
// the free pointer to the page size at once; the directory memory is not
// cleared.
module slotted_page_manager (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  command,
	input  logic [spm_pkg::LEN_W-1:0]   insert_length,
	input  logic [spm_pkg::SLOT_W-1:0]  slot_id,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [spm_pkg::SLOT_W-1:0]  result_slot,
	output logic [spm_pkg::LEN_W-1:0]   result_offset,
	output logic [spm_pkg::LEN_W-1:0]   result_length,
	output logic [spm_pkg::LEN_W-1:0]   free_bytes,
	output logic [spm_pkg::CNT_W-1:0]   slot_total
);

	spm_pkg::spm_ctl_t ctl;

	spm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	spm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.insert_length (insert_length),
		.slot_id       (slot_id),
		.done          (done),
		.status        (status),
		.result_slot   (result_slot),
		.result_offset (result_offset),
		.result_length (result_length),
		.free_bytes    (free_bytes),
		.slot_total    (slot_total)
	);

	// An accepted transaction raises busy, and its execute phase ends with done
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("execute phase did not end with a result");

	// A result only follows an execute cycle
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without an execute cycle");

	// Slot count never exceeds the directory size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> slot_total <= spm_pkg::CNT_W'(spm_pkg::MAX_SLOTS))
		else $error("slot count beyond directory size");

endmodule

// ===== rtl/spm_ctrl.sv =====
// Controller state machine: sequences capture and execute phases of each transaction.
`timescale 1ns / 1ps
module spm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output spm_pkg::spm_ctl_t ctl
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;

	// Advance state; hold busy through the execute cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Drive datapath commands
	assign busy     = busy_q;
	assign ctl.load = start && !busy_q;
	assign ctl.exec = (state_q == S_EXEC);

endmodule

// ===== rtl/spm_dp.sv =====
// Datapath: slot directory memory, page pointers and result registers.
`timescale 1ns / 1ps
module spm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spm_pkg::spm_ctl_t           ctl,
	input  logic [1:0]                  command,
	input  logic [spm_pkg::LEN_W-1:0]   insert_length,
	input  logic [spm_pkg::SLOT_W-1:0]  slot_id,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [spm_pkg::SLOT_W-1:0]  result_slot,
	output logic [spm_pkg::LEN_W-1:0]   result_offset,
	output logic [spm_pkg::LEN_W-1:0]   result_length,
	output logic [spm_pkg::LEN_W-1:0]   free_bytes,
	output logic [spm_pkg::CNT_W-1:0]   slot_total
);

	localparam int LW = spm_pkg::LEN_W;
	localparam int SW = spm_pkg::SLOT_W;
	localparam int CW = spm_pkg::CNT_W;
	localparam int XW = spm_pkg::EXT_W;

	// Directory memory: offset in upper half, length in lower half
	logic [2*LW-1:0] dir_mem [spm_pkg::MAX_SLOTS];
	logic [2*LW-1:0] rd_q;

	// Captured transaction
	spm_pkg::spm_cmd_t cmd_q;
	logic [LW-1:0]     len_q;
	logic [SW-1:0]     sid_q;

	// Page state
	logic [CW-1:0] count_q;
	logic [LW-1:0] free_q;

	// Result registers
	logic                 done_q;
	spm_pkg::spm_status_t status_q;
	logic [SW-1:0]        rslot_q;
	logic [LW-1:0]        roff_q;
	logic [LW-1:0]        rlen_q;
	logic [LW-1:0]        rfree_q;
	logic [CW-1:0]        rcount_q;

	// Execute-phase logic
	logic [XW-1:0]        dir_end;
	logic [XW-1:0]        free_ext;
	logic                 dir_fits;
	logic [XW-1:0]        gap;
	logic [XW-1:0]        need;
	logic                 ins_ok;
	logic                 sid_in;
	logic [LW-1:0]        rd_off;
	logic [LW-1:0]        rd_len;
	logic                 we;
	logic [SW-1:0]        waddr;
	logic [2*LW-1:0]      wdata;
	spm_pkg::spm_status_t nx_status;
	logic [SW-1:0]        nx_rslot;
	logic [LW-1:0]        nx_roff;
	logic [LW-1:0]        nx_rlen;
	logic [XW-1:0]        nx_gap;
	logic [CW-1:0]        nx_count;
	logic [LW-1:0]        nx_free;

	// Capture the transaction and read the addressed entry
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= spm_pkg::spm_cmd_t'(command);
			len_q <= insert_length;
			sid_q <= slot_id;
			rd_q  <= dir_mem[slot_id];
		end
	end

	// Write back the directory entry
	always_ff @(posedge clk) begin
		if (we) begin
			dir_mem[waddr] <= wdata;
		end
	end

	assign rd_off   = rd_q[2*LW-1:LW];
	assign rd_len   = rd_q[LW-1:0];
	assign dir_end  = XW'(spm_pkg::HEADER_BYTES) + {1'b0, count_q, 2'b00};
	assign free_ext = {1'b0, free_q};
	assign dir_fits = (dir_end <= free_ext);
	assign gap      = dir_fits ? (free_ext - dir_end) : '0;
	assign need     = {1'b0, len_q} + XW'(spm_pkg::ENTRY_BYTES);
	assign ins_ok   = (count_q < CW'(spm_pkg::MAX_SLOTS)) && dir_fits && (need <= gap);
	assign sid_in   = ({1'b0, sid_q} < count_q);

	// Decode the command and form the result and next state
	always_comb begin
		we        = 1'b0;
		waddr     = sid_q;
		wdata     = {rd_off, {LW{1'b0}}};
		nx_status = spm_pkg::ST_OK;
		nx_rslot  = '0;
		nx_roff   = '0;
		nx_rlen   = '0;
		nx_gap    = gap;
		nx_count  = count_q;
		nx_free   = free_q;
		unique case (cmd_q)
			spm_pkg::CMD_INSERT: begin
				if (ins_ok) begin
					we       = 1'b1;
					waddr    = count_q[SW-1:0];
					wdata    = {free_q - len_q, len_q};
					nx_rslot = count_q[SW-1:0];
					nx_roff  = free_q - len_q;
					nx_rlen  = len_q;
					nx_gap   = gap - need;
					nx_count = count_q + CW'(1);
					nx_free  = free_q - len_q;
				end else begin
					nx_status = spm_pkg::ST_NOSPACE;
				end
			end
			spm_pkg::CMD_GET: begin
				if (!sid_in || rd_len == '0) begin
					nx_status = spm_pkg::ST_NOENTRY;
				end else begin
					nx_roff = rd_off;
					nx_rlen = rd_len;
				end
			end
			spm_pkg::CMD_DELETE: begin
				if (!sid_in || (rd_off == '0 && rd_len == '0)) begin
					nx_status = spm_pkg::ST_NOENTRY;
				end else if (rd_len == '0) begin
					nx_status = spm_pkg::ST_DELETED;
				end else begin
					we = 1'b1;
				end
			end
			spm_pkg::CMD_INIT: begin
				nx_count = '0;
				nx_free  = LW'(spm_pkg::PAGE_BYTES);
				nx_gap   = XW'(spm_pkg::PAGE_BYTES - spm_pkg::HEADER_BYTES);
			end
			default: begin
				nx_status = spm_pkg::ST_OK;
			end
		endcase
	end

	// Update page pointers and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			free_q  <= LW'(spm_pkg::PAGE_BYTES);
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (ctl.exec) begin
				count_q <= nx_count;
				free_q  <= nx_free;
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= nx_status;
			rslot_q  <= nx_rslot;
			roff_q   <= nx_roff;
			rlen_q   <= nx_rlen;
			rfree_q  <= nx_gap[LW-1:0];
			rcount_q <= nx_count;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign result_slot   = rslot_q;
	assign result_offset = roff_q;
	assign result_length = rlen_q;
	assign free_bytes    = rfree_q;
	assign slot_total    = rcount_q;

endmodule
